[hdl/dtvcc_service_stream_checker_macros.svh]
// Assertion macros for the caption service stream checker.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef DTVCC_SERVICE_STREAM_CHECKER_MACROS_SVH
`define DTVCC_SERVICE_STREAM_CHECKER_MACROS_SVH
`ifndef SYNTH
// Clocked check that is switched off while reset is applied.
`define DTVCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked check that also holds while reset is applied.
`define DTVCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define DTVCC_ASSERT(lbl, prop, msg)
`define DTVCC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hdl/dtvcc_pkg.sv]
// Shared types, constants and code tables for the caption service stream checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dtvcc_pkg;

  localparam int unsigned LOSS_COUNTER_BITS = 16;
  localparam int unsigned LOSS_OUT_BITS     = 16;

  localparam int unsigned ROWS_W   = 5;
  localparam int unsigned COLS_W   = 7;
  localparam int unsigned ANCHOR_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [ROWS_W-1:0]   ROWS_RESET   = 5'd12;
  localparam logic [COLS_W-1:0]   COLS_RESET   = 7'd42;
  localparam logic [ANCHOR_W-1:0] ANCHOR_RESET = 4'd8;

  // Byte codes of the caption code sets.
  localparam logic [7:0] CODE_EXT1       = 8'h10;
  localparam logic [7:0] CODE_C0_LAST    = 8'h1F;
  localparam logic [7:0] CODE_C0_SHORT   = 8'h0F;
  localparam logic [7:0] CODE_P16        = 8'h17;
  localparam logic [7:0] CODE_EXT_C0_1   = 8'h07;
  localparam logic [7:0] CODE_G0_LAST    = 8'h7F;
  localparam logic [7:0] CODE_C1_FIRST   = 8'h80;
  localparam logic [7:0] CODE_C3_FIX4    = 8'h87;
  localparam logic [7:0] CODE_C3_FIX5    = 8'h8F;
  localparam logic [7:0] CODE_C1_LAST    = 8'h9F;
  localparam logic [7:0] CODE_VAR_FIRST  = 8'h90;
  localparam logic [7:0] CODE_DEFWIN_LO  = 8'h98;
  localparam logic [7:0] CODE_G3_CC      = 8'hA0;
  localparam logic [7:0] CODE_NUL        = 8'h00;
  localparam logic [7:0] CODE_ETX        = 8'h03;
  localparam logic [7:0] CODE_BS         = 8'h08;
  localparam logic [7:0] CODE_FF         = 8'h0C;
  localparam logic [7:0] CODE_CR         = 8'h0D;
  localparam logic [7:0] CODE_HCR        = 8'h0E;

  localparam logic [2:0] SERVICE_EXTENDED = 3'd7;

  // Parameter bytes left in a DefineWindow when the anchor/rows byte
  // and the column byte arrive.
  localparam logic [4:0] DEFWIN_LEFT_ANCHOR = 5'd3;
  localparam logic [4:0] DEFWIN_LEFT_COLS   = 5'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ROWS   = 2'd0,
    CFG_MAX_COLS   = 2'd1,
    CFG_MAX_ANCHOR = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ROWS_W-1:0]   max_rows;
    logic [COLS_W-1:0]   max_cols;
    logic [ANCHOR_W-1:0] max_anchor;
  } cfg_t;

  // Command walker state carried from byte to byte.
  typedef struct packed {
    logic [4:0] cmd_left;
    logic [7:0] cmd_code;
    logic       ext_seen;
    logic       cmd_ext;
    logic       len_pending;
  } walk_t;

  typedef struct packed {
    logic ctl;
    logic chr;
    logic pos;
    logic size;
  } walk_flags_t;

  typedef struct packed {
    logic                     seq_flag;
    logic [LOSS_OUT_BITS-1:0] loss_count;
  } hdr_res_t;

  // Parameter byte count that follows a C1 code (command length minus one).
  function automatic logic [2:0] c1_params(input logic [4:0] idx);
    logic [2:0] n;
    case (idx)
      5'h08, 5'h09, 5'h0A, 5'h0B, 5'h0C, 5'h0D: n = 3'd1;
      5'h10, 5'h12:                             n = 3'd2;
      5'h11:                                    n = 3'd3;
      5'h17:                                    n = 3'd4;
      5'h18, 5'h19, 5'h1A, 5'h1B,
      5'h1C, 5'h1D, 5'h1E, 5'h1F:               n = 3'd6;
      default:                                  n = 3'd0;
    endcase
    return n;
  endfunction

  // True for the G2 codes that carry a character.
  function automatic logic g2_used(input logic [7:0] b);
    logic u;
    case (b)
      8'h20, 8'h21, 8'h25, 8'h2A, 8'h2C,
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
      8'h39, 8'h3A, 8'h3C, 8'h3D, 8'h3F,
      8'h76, 8'h77, 8'h78, 8'h79, 8'h7A,
      8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h7F: u = 1'b1;
      default:                           u = 1'b0;
    endcase
    return u;
  endfunction

endpackage

[hdl/dtvcc_service_stream_checker.sv]
// Top level of the caption service stream checker: input and result registers,
// service block state and configuration. Depends on dtvcc_pkg, dtvcc_byte_walk,
// dtvcc_hdr_track and the assertion macro header.
//
// Usage:
//   Input beats carry is_packet_header_i and cc_pair_i under in_valid_i and
//   in_stall_o; result beats carry five per-item flags, the packet loss count
//   and the highest service seen, under out_valid_o and out_stall_i. Every
//   input beat gives exactly one result beat, in order.
//   A beat accepted at one clock edge is captured in the input register; an
//   edge with the result register empty or not stalled runs the whole
//   two-byte walk and loads the result register. One beat per cycle is
//   sustained unless the receiver stalls; the rate is set by the single walk
//   stage, two byte parsers in series between input and result registers.
//   If the receiver stalls, the result register holds and the input register
//   can still take one more beat before in_stall_o rises.
//   Configuration writes (cfg_index_i 0: max rows, 1: max columns, 2: max
//   anchor) are always ready; other indexes are ignored. Write only while idle.
//   Reset clears all sequence, service and command state and the loss count,
//   and returns the limits to 12 rows, 42 columns and anchor 8.
`timescale 1ns / 1ps
`include "dtvcc_service_stream_checker_macros.svh"

module dtvcc_service_stream_checker
  import dtvcc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     is_packet_header_i,
  input  logic [15:0]              cc_pair_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     seq_discontinuity_o,
  output logic                     bad_control_code_o,
  output logic                     bad_character_o,
  output logic                     bad_window_position_o,
  output logic                     bad_window_size_o,
  output logic [LOSS_OUT_BITS-1:0] packet_loss_count_o,
  output logic [5:0]               highest_service_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  cfg_t cfg_q, cfg_d;

  logic        in_full_q, in_full_d;
  logic        in_hdr_q;
  logic [15:0] in_cc_q;
  logic        accept, advance;

  logic        out_valid_q, out_valid_d;
  logic        seq_q, ctl_q, chr_q, pos_q, size_q;
  logic [LOSS_OUT_BITS-1:0] loss_out_q;
  logic [5:0]  high_q, high_d;

  logic [5:0]  svc_q, svc_d;
  logic [5:0]  blk_q, blk_d;
  logic        ext_pend_q, ext_pend_d;
  walk_t       walk_q, walk_d;

  walk_t       walk_mid, walk_end;
  walk_flags_t flags0, flags1, flags_d;
  logic        data_walk;
  hdr_res_t    hdr_res;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_ROWS:   cfg_d.max_rows   = cfg_data_i[ROWS_W-1:0];
        CFG_MAX_COLS:   cfg_d.max_cols   = cfg_data_i[COLS_W-1:0];
        CFG_MAX_ANCHOR: cfg_d.max_anchor = cfg_data_i[ANCHOR_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign advance    = in_full_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_full_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_full_d  = accept || (in_full_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  // ---------------- walk ----------------
  dtvcc_byte_walk u_walk_hi (
    .byte_i  (in_cc_q[15:8]),
    .st_i    (walk_q),
    .cfg_i   (cfg_q),
    .st_o    (walk_mid),
    .flags_o (flags0)
  );

  dtvcc_byte_walk u_walk_lo (
    .byte_i  (in_cc_q[7:0]),
    .st_i    (walk_mid),
    .cfg_i   (cfg_q),
    .st_o    (walk_end),
    .flags_o (flags1)
  );

  dtvcc_hdr_track u_hdr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hdr_adv_i (advance && in_hdr_q),
    .seq_i     (in_cc_q[15:14]),
    .res_o     (hdr_res)
  );

  // A data pair is walked only inside a live, non-empty service block.
  assign data_walk = !in_hdr_q && !ext_pend_q && (svc_q != 6'd0) &&
                     !blk_q[5] && (blk_q != 6'd0);

  always_comb begin
    svc_d      = svc_q;
    blk_d      = blk_q;
    ext_pend_d = ext_pend_q;
    walk_d     = walk_q;
    flags_d    = '0;
    if (advance) begin
      if (in_hdr_q) begin
        svc_d      = {3'b000, in_cc_q[7:5]};
        blk_d      = {1'b0, in_cc_q[4:0]};
        ext_pend_d = (in_cc_q[7:5] == SERVICE_EXTENDED) && (in_cc_q[4:0] != 5'd0);
      end else if (ext_pend_q) begin
        svc_d      = in_cc_q[5:0];
        ext_pend_d = 1'b0;
      end else if (data_walk) begin
        walk_d = walk_end;
        blk_d  = blk_q - 6'd2;
        flags_d.ctl  = flags0.ctl | flags1.ctl |
                       ($signed({2'b00, walk_end.cmd_left}) > $signed({blk_d[5], blk_d}));
        flags_d.chr  = flags0.chr | flags1.chr;
        flags_d.pos  = flags0.pos | flags1.pos;
        flags_d.size = flags0.size | flags1.size;
      end
    end
    high_d = (svc_d > high_q) ? svc_d : high_q;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_rows   <= ROWS_RESET;
      cfg_q.max_cols   <= COLS_RESET;
      cfg_q.max_anchor <= ANCHOR_RESET;
      in_full_q   <= 1'b0;
      out_valid_q <= 1'b0;
      svc_q       <= '0;
      blk_q       <= '0;
      ext_pend_q  <= 1'b0;
      walk_q      <= '0;
      high_q      <= '0;
    end else begin
      cfg_q       <= cfg_d;
      in_full_q   <= in_full_d;
      out_valid_q <= out_valid_d;
      svc_q       <= svc_d;
      blk_q       <= blk_d;
      ext_pend_q  <= ext_pend_d;
      walk_q      <= walk_d;
      high_q      <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_hdr_q <= is_packet_header_i;
      in_cc_q  <= cc_pair_i;
    end
    if (advance) begin
      seq_q      <= in_hdr_q && hdr_res.seq_flag;
      ctl_q      <= flags_d.ctl;
      chr_q      <= flags_d.chr;
      pos_q      <= flags_d.pos;
      size_q     <= flags_d.size;
      loss_out_q <= hdr_res.loss_count;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign seq_discontinuity_o   = seq_q;
  assign bad_control_code_o    = ctl_q;
  assign bad_character_o       = chr_q;
  assign bad_window_position_o = pos_q;
  assign bad_window_size_o     = size_q;
  assign packet_loss_count_o   = loss_out_q;
  assign highest_service_o     = high_q;

  `DTVCC_ASSERT(a_blk_floor, !(blk_q[5] && (blk_q != 6'h3F)), "block count below minus one")
  `DTVCC_ASSERT(a_ext_pend_service, ext_pend_q |-> (svc_q == {3'b000, SERVICE_EXTENDED}), "extended header pending outside service 7")
  `DTVCC_ASSERT(a_len_pending_shape, walk_q.len_pending |-> (walk_q.cmd_ext && (walk_q.cmd_left == 5'd1)), "length byte pending with wrong command state")
  `DTVCC_ASSERT(a_high_monotonic, 1'b1 |=> (high_q >= $past(high_q)), "highest service decreased")
  `DTVCC_ASSERT_ALWAYS(a_no_advance_empty, advance |-> in_full_q, "walk advanced with empty input register")

endmodule

[hdl/dtvcc_byte_walk.sv]
// Walks one service block byte through the command parser and flags errors.
// Purely combinational; depends on dtvcc_pkg.
`timescale 1ns / 1ps

module dtvcc_byte_walk
  import dtvcc_pkg::*;
(
  input  logic [7:0]  byte_i,
  input  walk_t       st_i,
  input  cfg_t        cfg_i,
  output walk_t       st_o,
  output walk_flags_t flags_o
);

  logic [4:0] left_v;
  logic [5:0] rows_v;
  logic [6:0] cols_v;

  always_comb begin
    st_o    = st_i;
    flags_o = '0;
    left_v  = st_i.cmd_left;
    rows_v  = {2'b00, byte_i[3:0]} + 6'd1;
    cols_v  = {1'b0, byte_i[5:0]} + 7'd1;
    if (st_i.cmd_left == 5'd0) begin
      st_o.cmd_code = byte_i;
      st_o.cmd_ext  = st_i.ext_seen;
      if (byte_i == CODE_EXT1) begin
        st_o.ext_seen = 1'b1;
      end else if (byte_i <= CODE_C0_LAST) begin
        if (st_i.ext_seen) begin
          if (byte_i <= CODE_EXT_C0_1) begin
            st_o.cmd_left = 5'd0;
          end else if (byte_i <= CODE_C0_SHORT) begin
            st_o.cmd_left = 5'd1;
          end else if (byte_i <= CODE_P16) begin
            st_o.cmd_left = 5'd2;
          end else begin
            st_o.cmd_left = 5'd3;
          end
        end else if (byte_i <= CODE_C0_SHORT) begin
          if (!(byte_i == CODE_NUL || byte_i == CODE_ETX || byte_i == CODE_BS ||
                byte_i == CODE_FF || byte_i == CODE_CR || byte_i == CODE_HCR)) begin
            flags_o.ctl = 1'b1;
          end
          st_o.cmd_left = 5'd0;
        end else if (byte_i < CODE_P16) begin
          st_o.cmd_left = 5'd1;
        end else begin
          st_o.cmd_left = 5'd2;
        end
        st_o.ext_seen = 1'b0;
      end else if (byte_i <= CODE_G0_LAST) begin
        flags_o.chr   = st_i.ext_seen && !g2_used(byte_i);
        st_o.cmd_left = 5'd0;
        st_o.ext_seen = 1'b0;
      end else if (byte_i <= CODE_C1_LAST) begin
        if (st_i.ext_seen) begin
          if (byte_i == CODE_C1_FIRST) begin
            flags_o.ctl = 1'b1;
          end else if (byte_i <= CODE_C3_FIX4) begin
            st_o.cmd_left = 5'd4;
          end else if (byte_i <= CODE_C3_FIX5) begin
            st_o.cmd_left = 5'd5;
          end else begin
            st_o.cmd_left    = 5'd1;
            st_o.len_pending = 1'b1;
          end
        end else begin
          st_o.cmd_left = {2'b00, c1_params(byte_i[4:0])};
        end
        st_o.ext_seen = 1'b0;
      end else begin
        flags_o.chr   = st_i.ext_seen && (byte_i != CODE_G3_CC);
        st_o.cmd_left = 5'd0;
        st_o.ext_seen = 1'b0;
      end
    end else begin
      if (st_i.cmd_code >= CODE_DEFWIN_LO && !st_i.cmd_ext) begin
        // DefineWindow: anchor/row byte, then the column byte.
        if (st_i.cmd_left == DEFWIN_LEFT_ANCHOR) begin
          flags_o.pos  = byte_i[7:4] > cfg_i.max_anchor;
          flags_o.size = rows_v > {1'b0, cfg_i.max_rows};
        end else if (st_i.cmd_left == DEFWIN_LEFT_COLS) begin
          flags_o.size = cols_v > cfg_i.max_cols;
        end
      end else if (st_i.cmd_code >= CODE_VAR_FIRST && st_i.cmd_code <= CODE_C1_LAST &&
                   st_i.cmd_ext && st_i.len_pending) begin
        left_v           = byte_i[4:0];
        st_o.len_pending = 1'b0;
      end
      st_o.cmd_left = (left_v != 5'd0) ? left_v - 5'd1 : 5'd0;
    end
  end

endmodule

[hdl/dtvcc_hdr_track.sv]
// Packet header sequence tracking and lost-packet window counter.
// Depends on dtvcc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "dtvcc_service_stream_checker_macros.svh"

module dtvcc_hdr_track
  import dtvcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       hdr_adv_i,
  input  logic [1:0] seq_i,
  output hdr_res_t   res_o
);

  logic [1:0]                   last_seq_q, last_seq_d;
  logic [3:0]                   mask_q, mask_d, mask_v;
  logic [1:0]                   count_q, count_d;
  logic [LOSS_COUNTER_BITS-1:0] loss_q, loss_d;

  always_comb begin
    last_seq_d = last_seq_q;
    mask_d     = mask_q;
    count_d    = count_q;
    loss_d     = loss_q;
    mask_v     = mask_q | (4'b0001 << seq_i);
    if (hdr_adv_i) begin
      last_seq_d = seq_i;
      if (count_q == 2'd3) begin
        if (mask_v != 4'hF && loss_q != '1) begin
          loss_d = loss_q + 1'b1;
        end
        count_d = 2'd0;
        mask_d  = 4'h0;
      end else begin
        count_d = count_q + 2'd1;
        mask_d  = mask_v;
      end
    end
  end

  assign res_o.seq_flag   = (seq_i != last_seq_q + 2'd1);
  assign res_o.loss_count = LOSS_OUT_BITS'(loss_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q <= '0;
      mask_q     <= '0;
      count_q    <= '0;
      loss_q     <= '0;
    end else begin
      last_seq_q <= last_seq_d;
      mask_q     <= mask_d;
      count_q    <= count_d;
      loss_q     <= loss_d;
    end
  end

  `DTVCC_ASSERT(a_mask_empty_at_window_start, (count_q == 2'd0) |-> (mask_q == 4'h0), "mask not cleared at window start")
  `DTVCC_ASSERT(a_loss_only_on_header, !hdr_adv_i |=> $stable(loss_q), "loss count moved without a header")
  `DTVCC_ASSERT(a_count_only_on_header, !hdr_adv_i |=> $stable(count_q), "header count moved without a header")

endmodule
